>>> rtl/core/brs_pkg.sv
// Shared types, constants and helpers for the BMP row nearest scaler.
// Used by the scaler, divider and checker under rtl/core; depends on nothing.
package brs_pkg;

    localparam int MAX_SRC_WIDTH = 8192;
    localparam int POS_BITS      = 14;
    localparam int ADDR_BITS     = $clog2(MAX_SRC_WIDTH);

    localparam int SRCW_BITS = 14;
    localparam int SRCH_BITS = 16;
    localparam int DST_BITS  = 12;
    localparam int SIZE_BITS = 16;
    localparam int PIX_BITS  = 16;

    localparam int DIV_Q_BITS = 16;
    localparam int DIV_D_BITS = DST_BITS;
    localparam int DIV_N_BITS = DIV_Q_BITS + DIV_D_BITS;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TOP_DOWN   = 3'd4;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_ROW   = 2'd2;

    localparam logic STATUS_GOOD = 1'b0;
    localparam logic STATUS_ERR  = 1'b1;

    typedef struct packed {
        logic [1:0]          func;
        logic [POS_BITS-1:0] position;
        logic [7:0]          first_byte;
        logic [7:0]          second_byte;
        logic [7:0]          third_byte;
    } brs_in_t;

    typedef struct packed {
        logic [PIX_BITS-1:0]  pixel_word;
        logic [SIZE_BITS-1:0] source_row;
        logic                 status;
    } brs_out_t;

    function automatic logic [PIX_BITS-1:0] pack_rgb565(
        input logic [7:0] b0,
        input logic [7:0] b1,
        input logic [7:0] b2
    );
        return {b0[7:3], b1[7:2], b2[7:3]};
    endfunction

endpackage

>>> rtl/core/bmp_row_nearest_scaler_rgb565.sv
// Path from accepted word to result: a pixel write or an error goes from the done state
// to the output register; a row map runs multiply, divider load, 16 divider steps,
// done flag and output register, and a pixel read adds one line store read.
// Flow: one word in flight; the next word is taken once the result sits
// in the output register.
// Reset is synchronous, active low; configuration returns to defaults, line store kept.
module bmp_row_nearest_scaler_rgb565 (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  brs_pkg::brs_in_t                   s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output brs_pkg::brs_out_t                  m_data,
    input  logic                               cfg_we,
    input  logic [brs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [brs_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
    import brs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_READ,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [SRCW_BITS-1:0] src_width_reg;
    logic [SRCH_BITS-1:0] src_height_reg;
    logic [DST_BITS-1:0]  dst_width_reg;
    logic [DST_BITS-1:0]  dst_height_reg;
    logic                 top_down_reg;

    logic [1:0]            func_reg;
    logic                  status_reg;
    logic [DST_BITS-1:0]   pos_reg;
    logic [SIZE_BITS-1:0]  op_n_reg;
    logic [DIV_D_BITS-1:0] op_d_reg;
    logic                  degen_reg;
    logic                  mirror_reg;
    logic [DIV_N_BITS-1:0] prod_reg;
    logic                  div_start_reg;
    logic                  m_valid_reg;
    brs_out_t              m_data_reg;

    logic [SIZE_BITS-1:0]  pos16;
    logic [SIZE_BITS-1:0]  src_w16;
    logic [SIZE_BITS-1:0]  eff_w;
    logic                  accept;
    logic                  in_err;
    logic                  in_scaled;
    logic [SIZE_BITS-1:0]  in_n;
    logic [DST_BITS-1:0]   in_dst;
    logic                  in_degen;

    logic                  div_done;
    logic [DIV_Q_BITS-1:0] div_q;
    logic                  ram_we;
    logic                  ram_re;
    logic [ADDR_BITS-1:0]  ram_addr;
    logic [PIX_BITS-1:0]   ram_rdata;
    logic                  out_free;
    brs_out_t              result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= SRCW_BITS'(1);
            src_height_reg <= SRCH_BITS'(1);
            dst_width_reg  <= DST_BITS'(240);
            dst_height_reg <= DST_BITS'(135);
            top_down_reg   <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SRC_WIDTH:  src_width_reg  <= cfg_wdata[SRCW_BITS-1:0];
                CFG_SRC_HEIGHT: src_height_reg <= cfg_wdata[SRCH_BITS-1:0];
                CFG_DST_WIDTH:  dst_width_reg  <= cfg_wdata[DST_BITS-1:0];
                CFG_DST_HEIGHT: dst_height_reg <= cfg_wdata[DST_BITS-1:0];
                CFG_TOP_DOWN:   top_down_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        pos16   = SIZE_BITS'(s_data.position);
        src_w16 = SIZE_BITS'(src_width_reg);
        if (src_width_reg == '0) begin
            eff_w = SIZE_BITS'(1);
        end else if (src_w16 > SIZE_BITS'(MAX_SRC_WIDTH)) begin
            eff_w = SIZE_BITS'(MAX_SRC_WIDTH);
        end else begin
            eff_w = src_w16;
        end

        in_scaled = 1'b0;
        in_n      = src_height_reg - 1'b1;
        in_dst    = dst_height_reg;
        in_degen  = (src_height_reg <= SIZE_BITS'(1));
        unique case (s_data.func)
            FUNC_WRITE: in_err = !(pos16 < eff_w);
            FUNC_READ: begin
                in_err    = !(pos16 < SIZE_BITS'(dst_width_reg));
                in_scaled = !in_err;
                in_n      = eff_w - 1'b1;
                in_dst    = dst_width_reg;
                in_degen  = (eff_w <= SIZE_BITS'(1));
            end
            FUNC_ROW: begin
                in_err    = !(pos16 < SIZE_BITS'(dst_height_reg));
                in_scaled = !in_err;
            end
            default: in_err = 1'b1;
        endcase
        in_degen = in_degen || (in_dst <= DST_BITS'(1));
    end

    assign ram_we   = accept && (s_data.func == FUNC_WRITE) && !in_err;
    assign ram_re   = (state_reg == ST_READ);
    assign ram_addr = ram_we ? s_data.position[ADDR_BITS-1:0] : div_q[ADDR_BITS-1:0];
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = in_scaled ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL: state_next = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    state_next = (func_reg == FUNC_READ) ? ST_READ : ST_DONE;
                end
            end
            ST_READ: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        result            = '0;
        result.status     = status_reg;
        if (status_reg == STATUS_GOOD) begin
            if (func_reg == FUNC_READ) begin
                result.pixel_word = ram_rdata;
            end else if (func_reg == FUNC_ROW) begin
                result.source_row = mirror_reg ? (op_n_reg - div_q) : div_q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            div_start_reg <= (state_reg == ST_MUL);
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            func_reg   <= s_data.func;
            status_reg <= in_err ? STATUS_ERR : STATUS_GOOD;
            pos_reg    <= s_data.position[DST_BITS-1:0];
            op_n_reg   <= in_n;
            op_d_reg   <= in_degen ? DIV_D_BITS'(1) : (in_dst - 1'b1);
            degen_reg  <= in_degen;
            mirror_reg <= !in_degen && !top_down_reg;
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= degen_reg ? '0 : pos_reg * op_n_reg;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg <= result;
        end
    end

    brs_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (prod_reg),
        .divisor  (op_d_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    brs_line_ram #(
        .DEPTH (MAX_SRC_WIDTH),
        .WIDTH (PIX_BITS)
    ) u_line (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (pack_rgb565(s_data.first_byte, s_data.second_byte, s_data.third_byte)),
        .rdata (ram_rdata)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> rtl/core/brs_line_ram.sv
// Single-port line store RAM: one write and one registered read per cycle, on one address.
// Generic; no package dependency.
module brs_line_ram #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/brs_divider.sv
// Restoring divider, one quotient bit per cycle, for the position scaling.
// Depends on brs_pkg for operand widths.
module brs_divider (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [brs_pkg::DIV_N_BITS-1:0]  dividend,
    input  logic [brs_pkg::DIV_D_BITS-1:0]  divisor,
    output logic                            done,
    output logic [brs_pkg::DIV_Q_BITS-1:0]  quotient
);
    import brs_pkg::*;

    localparam int CNT_BITS = $clog2(DIV_Q_BITS);
    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(DIV_Q_BITS - 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [DIV_D_BITS-1:0] rem_reg;
    logic [DIV_D_BITS-1:0] rem_next;
    logic [DIV_D_BITS-1:0] div_reg;
    logic [DIV_Q_BITS-1:0] quo_reg;
    logic [DIV_D_BITS+1:0] diff;
    logic                  qbit;

    always_comb begin
        diff     = {1'b0, rem_reg, quo_reg[DIV_Q_BITS-1]} - {2'b00, div_reg};
        qbit     = ~diff[DIV_D_BITS+1];
        rem_next = qbit ? diff[DIV_D_BITS-1:0]
                        : {rem_reg[DIV_D_BITS-2:0], quo_reg[DIV_Q_BITS-1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[DIV_N_BITS-1:DIV_Q_BITS];
            quo_reg <= dividend[DIV_Q_BITS-1:0];
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_Q_BITS-2:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/core/brs_checker.sv
// Port-level checks for the BMP row nearest scaler, bound to the top level.
// Depends on brs_pkg and bmp_row_nearest_scaler_rgb565.
module brs_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input brs_pkg::brs_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input brs_pkg::brs_out_t m_data
);
    import brs_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while one is in flight");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STATUS_ERR) |->
            (m_data.pixel_word == '0) && (m_data.source_row == '0))
        else $error("error result carries nonzero fields");

    a_one_field: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.pixel_word != '0) |-> (m_data.source_row == '0))
        else $error("pixel and row both set");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind bmp_row_nearest_scaler_rgb565 brs_checker u_brs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> tb/bmp_row_nearest_scaler_rgb565_tb.sv
// Self-checking testbench for bmp_row_nearest_scaler_rgb565: directed size and range cases,
// then random pixel writes, pixel reads and row maps under random valid/ready idling.
// Depends on brs_pkg and the scaler RTL only.
`timescale 1ns / 1ps

module bmp_row_nearest_scaler_rgb565_tb;
    import brs_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    brs_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    brs_out_t m_data;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;

    bmp_row_nearest_scaler_rgb565 dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    logic [PIX_BITS-1:0] line_copy [MAX_SRC_WIDTH];
    bit                  line_written [MAX_SRC_WIDTH];
    logic [13:0]         cur_src_w;
    logic [15:0]         cur_src_h;
    logic [11:0]         cur_dst_w;
    logic [11:0]         cur_dst_h;
    logic                cur_top_down;

    brs_out_t pending_results [$];
    int       mismatch_count;
    int       snd_idle_pct;
    int       rcv_idle_pct;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("FAIL bmp_row_nearest_scaler_rgb565");
        $finish;
    end

    function automatic int unsigned effective_width();
        int unsigned w;
        w = cur_src_w;
        if (w == 0) w = 1;
        if (w > MAX_SRC_WIDTH) w = MAX_SRC_WIDTH;
        return w;
    endfunction

    function automatic int unsigned scaled_index(input longint unsigned pos,
                                                 input longint unsigned src_n,
                                                 input longint unsigned dst_n);
        if (src_n <= 1 || dst_n <= 1) return 0;
        return int'((pos * (src_n - 1)) / (dst_n - 1));
    endfunction

    function automatic brs_out_t compute_result(input brs_in_t w);
        brs_out_t    r;
        int unsigned eff_w;
        int unsigned sx;
        int unsigned t;
        r = '0;
        eff_w = effective_width();
        case (w.func)
            FUNC_WRITE: begin
                if (w.position < eff_w) begin
                    line_copy[w.position[ADDR_BITS-1:0]] = {w.first_byte[7:3],
                                                            w.second_byte[7:2],
                                                            w.third_byte[7:3]};
                    line_written[w.position[ADDR_BITS-1:0]] = 1'b1;
                end else begin
                    r.status = STATUS_ERR;
                end
            end
            FUNC_READ: begin
                if (w.position < cur_dst_w) begin
                    sx = scaled_index(w.position, eff_w, cur_dst_w);
                    r.pixel_word = line_copy[sx[ADDR_BITS-1:0]];
                end else begin
                    r.status = STATUS_ERR;
                end
            end
            FUNC_ROW: begin
                if (w.position < cur_dst_h) begin
                    t = scaled_index(w.position, cur_src_h, cur_dst_h);
                    if (cur_src_h > 1 && cur_dst_h > 1 && !cur_top_down)
                        t = cur_src_h - 1 - t;
                    r.source_row = t[15:0];
                end else begin
                    r.status = STATUS_ERR;
                end
            end
            default: r.status = STATUS_ERR;
        endcase
        return r;
    endfunction

    function automatic brs_in_t word_of(input logic [1:0] f, input logic [13:0] p,
                                        input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2);
        brs_in_t w;
        w.func        = f;
        w.position    = p;
        w.first_byte  = b0;
        w.second_byte = b1;
        w.third_byte  = b2;
        return w;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    always @(posedge aclk) begin : result_check
        brs_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word: %p", m_data);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.pixel_word !== want.pixel_word) begin
                    $error("pixel_word mismatch: expected %h, got %h",
                           want.pixel_word, m_data.pixel_word);
                    mismatch_count++;
                end
                if (m_data.source_row !== want.source_row) begin
                    $error("source_row mismatch: expected %0d, got %0d",
                           want.source_row, m_data.source_row);
                    mismatch_count++;
                end
                if (m_data.status !== want.status) begin
                    $error("status mismatch: expected %b, got %b", want.status, m_data.status);
                    mismatch_count++;
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    task automatic send_word(input brs_in_t w);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_results.push_back(compute_result(w));
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // fill the source pixel first when a read would land on an unwritten entry
    task automatic send_pixel_read(input logic [13:0] pos);
        int unsigned sx;
        if (pos < cur_dst_w) begin
            sx = scaled_index(pos, effective_width(), cur_dst_w);
            if (!line_written[sx[ADDR_BITS-1:0]])
                send_word(word_of(FUNC_WRITE, sx[13:0], rand_byte(), rand_byte(), rand_byte()));
        end
        send_word(word_of(FUNC_READ, pos, rand_byte(), rand_byte(), rand_byte()));
    endtask

    task automatic cfg_put(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic apply_config(input int unsigned sw, input int unsigned sh,
                                input int unsigned dw, input int unsigned dh,
                                input bit td);
        wait_results_drained();
        repeat (4) @(posedge aclk);
        cfg_put(CFG_SRC_WIDTH, sw[15:0]);
        cfg_put(CFG_SRC_HEIGHT, sh[15:0]);
        cfg_put(CFG_DST_WIDTH, dw[15:0]);
        cfg_put(CFG_DST_HEIGHT, dh[15:0]);
        cfg_put(CFG_TOP_DOWN, {15'd0, td});
        cfg_we       <= 1'b0;
        cur_src_w    = sw[13:0];
        cur_src_h    = sh[15:0];
        cur_dst_w    = dw[11:0];
        cur_dst_h    = dh[11:0];
        cur_top_down = td;
    endtask

    task automatic test_reset_values();
        send_word(word_of(FUNC_WRITE, 14'd0, 8'hFF, 8'hFF, 8'hFF));
        send_word(word_of(FUNC_WRITE, 14'd1, 8'h00, 8'h00, 8'h00));
        send_pixel_read(14'd0);
        send_pixel_read(14'd239);
        send_pixel_read(14'd240);
        send_word(word_of(FUNC_ROW, 14'd0, 8'h00, 8'h00, 8'h00));
        send_word(word_of(FUNC_ROW, 14'd135, 8'h00, 8'h00, 8'h00));
        send_word(word_of(FUNC_UNUSED, 14'h3FFF, 8'hFF, 8'hFF, 8'hFF));
    endtask

    task automatic test_size_extremes();
        apply_config(8192, 65535, 4095, 4095, 1'b0);
        send_word(word_of(FUNC_WRITE, 14'd8191, 8'hA5, 8'h5A, 8'hC3));
        send_word(word_of(FUNC_WRITE, 14'd0, 8'h00, 8'h00, 8'h00));
        send_word(word_of(FUNC_WRITE, 14'd8192, 8'h3C, 8'hC3, 8'h7E));
        send_word(word_of(FUNC_WRITE, 14'h3FFF, 8'hFF, 8'hFF, 8'hFF));
        send_pixel_read(14'd4094);
        send_pixel_read(14'd0);
        send_pixel_read(14'd4095);
        send_word(word_of(FUNC_ROW, 14'd0, 8'h00, 8'h00, 8'h00));
        send_word(word_of(FUNC_ROW, 14'd4094, 8'h00, 8'h00, 8'h00));
        send_word(word_of(FUNC_ROW, 14'd4095, 8'h00, 8'h00, 8'h00));
        apply_config(8192, 65535, 4095, 4095, 1'b1);
        send_word(word_of(FUNC_ROW, 14'd4094, 8'h00, 8'h00, 8'h00));
    endtask

    task automatic test_degenerate_sizes();
        apply_config(0, 0, 1, 1, 1'b0);
        send_word(word_of(FUNC_WRITE, 14'd1, 8'h12, 8'h34, 8'h56));
        send_pixel_read(14'd0);
        send_word(word_of(FUNC_ROW, 14'd0, 8'h00, 8'h00, 8'h00));
        apply_config(16383, 2, 0, 0, 1'b0);
        send_word(word_of(FUNC_WRITE, 14'd8192, 8'h81, 8'h42, 8'h24));
        send_pixel_read(14'd0);
        send_word(word_of(FUNC_ROW, 14'd0, 8'h00, 8'h00, 8'h00));
    endtask

    task automatic randomize_config();
        case ($urandom_range(0, 9))
            0: apply_config(($urandom_range(0, 1) != 0) ? 8192 : $urandom_range(8193, 16383),
                            $urandom_range(60000, 65535), $urandom_range(4000, 4095),
                            $urandom_range(4000, 4095), 1'($urandom_range(0, 1)));
            1: apply_config($urandom_range(0, 1), $urandom_range(0, 2), $urandom_range(0, 2),
                            $urandom_range(0, 2), 1'($urandom_range(0, 1)));
            default: apply_config($urandom_range(1, 64), $urandom_range(1, 2000),
                                  $urandom_range(1, 300), $urandom_range(1, 300),
                                  1'($urandom_range(0, 1)));
        endcase
    endtask

    task automatic random_item();
        int unsigned sel;
        int unsigned eff_w;
        int unsigned pos;
        sel   = $urandom_range(0, 99);
        eff_w = effective_width();
        if (sel < 35) begin
            pos = ($urandom_range(0, 9) != 0) ? $urandom_range(0, eff_w - 1)
                                               : $urandom_range(eff_w, 16383);
            send_word(word_of(FUNC_WRITE, pos[13:0], rand_byte(), rand_byte(), rand_byte()));
        end else if (sel < 70) begin
            pos = (cur_dst_w != 0 && $urandom_range(0, 9) != 0)
                  ? $urandom_range(0, cur_dst_w - 1) : $urandom_range(cur_dst_w, 16383);
            send_pixel_read(pos[13:0]);
        end else if (sel < 92) begin
            pos = (cur_dst_h != 0 && $urandom_range(0, 9) != 0)
                  ? $urandom_range(0, cur_dst_h - 1) : $urandom_range(cur_dst_h, 16383);
            send_word(word_of(FUNC_ROW, pos[13:0], rand_byte(), rand_byte(), rand_byte()));
        end else begin
            send_word(word_of(FUNC_UNUSED, 14'($urandom_range(0, 16383)), rand_byte(),
                              rand_byte(), rand_byte()));
        end
    endtask

    task automatic test_random_traffic(input int n_configs, input int items_per_config);
        for (int c = 0; c < n_configs; c++) begin
            randomize_config();
            for (int i = 0; i < items_per_config; i++) begin
                if ($urandom_range(0, 59) == 0)
                    wait_results_drained();
                random_item();
            end
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        m_ready   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        mismatch_count = 0;
        snd_idle_pct   = 34;
        rcv_idle_pct   = 86;
        cur_src_w      = 14'd1;
        cur_src_h      = 16'd1;
        cur_dst_w      = 12'd240;
        cur_dst_h      = 12'd135;
        cur_top_down   = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_size_extremes();
        test_degenerate_sizes();
        test_random_traffic(4, 110);
        snd_idle_pct = 86;
        rcv_idle_pct = 34;
        test_random_traffic(4, 110);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random_traffic(4, 110);

        wait_results_drained();
        repeat (30) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASS bmp_row_nearest_scaler_rgb565");
        else
            $display("FAIL bmp_row_nearest_scaler_rgb565");
        $finish;
    end

endmodule
